>>> design/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 decoder with source position
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // field widths of the item structs
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned LINE_W = 24;
    localparam int unsigned COL_W  = 16;

    // default counter widths
    localparam int unsigned LINE_BITS_DEF = 24;
    localparam int unsigned COL_BITS_DEF  = 16;

    // reset value of the invalid replacement code
    localparam logic [CP_W-1:0] INVALID_CODE_RST = 21'h00FFFD;

    // special code points
    localparam logic [CP_W-1:0] CP_LINE_FEED = 21'h00000A;
    localparam logic [CP_W-1:0] CP_TAB       = 21'h000009;

    // range limits for complete sequences
    localparam logic [CP_W-1:0] CP_MIN_2B    = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3B    = 21'h000800;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN_4B    = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    // lead byte prefixes
    localparam logic [2:0] LEAD2_PFX = 3'h6;
    localparam logic [3:0] LEAD3_PFX = 4'hE;
    localparam logic [4:0] LEAD4_PFX = 5'h1E;
    localparam logic [1:0] CONT_PFX  = 2'h2;

    // continuation counts
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic              invalid;
        logic [LEN_W-1:0]  seq_len;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  byte_column;
        logic [COL_W-1:0]  char_column;
        logic              last_of_run;
    } t_out_item;

endpackage

>>> design/utf8_decoder_with_position_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_with_position_unit
// utf-8 byte stream decoder that tags each code point with line and columns
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_stall    o_out_item (t_out_item)
// cfg       input      i_cfg_we                     i_cfg_data (invalid code)
//
// one byte per cycle while not stalled; a byte that yields n results holds the job register
// until all n are popped (a broken sequence flushes up to three), input stalls meanwhile
// from byte accept to result valid a byte passes the job reg, then the out reg
// a byte that only extends a pending sequence yields no result
// synchronous active-low reset: nothing pending, counters at one,
// invalid code back to fffd
// output stall backs up through the job register into o_in_stall
// ----------------------------------------------------------------------------
module utf8_decoder_with_position_unit
    import utf8d_pkg::*;
#(
    parameter int unsigned LINE_BITS = LINE_BITS_DEF,
    parameter int unsigned COL_BITS  = COL_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CP_W-1:0] i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out_item
);

    // ---------------------------------------------------------------- config
    logic [CP_W-1:0] r_invalid_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_code <= INVALID_CODE_RST;
        end else if (i_cfg_we) begin
            r_invalid_code <= i_cfg_data;
        end
    end

    // -------------------------------------------------------- decoder state
    logic [7:0] r_lead, n_lead;
    logic [1:0] r_needed, n_needed;
    logic [1:0] r_have, n_have;
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;

    // job register: flush count of invalid length-1 results, then a final one
    logic [1:0]       r_job_flush, n_job_flush;
    logic             r_job_final, n_job_final;
    logic [CP_W-1:0]  r_job_cp, n_job_cp;
    logic             r_job_bad, n_job_bad;
    logic [LEN_W-1:0] r_job_len, n_job_len;

    // result register and position counters
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item, n_out_item;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [COL_BITS-1:0]  r_bcol, n_bcol;
    logic [COL_BITS-1:0]  r_ccol, n_ccol;

    // ------------------------------------------------------- handshake glue
    logic job_empty;
    logic job_last_one;
    logic pop;
    logic accept;

    assign job_empty    = (r_job_flush == 2'd0) && !r_job_final;
    assign job_last_one = ((r_job_flush == 2'd0) && r_job_final) ||
                          ((r_job_flush == 2'd1) && !r_job_final);
    assign pop          = !job_empty && (!r_out_valid || !i_out_stall);
    // take a new byte once the job drains this cycle at the latest
    assign o_in_stall   = !(job_empty || (job_last_one && pop));
    assign accept       = i_in_valid && !o_in_stall;

    // --------------------------------------------------------- byte decode
    logic [7:0]      b;
    logic            eos;
    logic            is_cont;
    logic [1:0]      f_need;
    logic            seq_done;
    logic [CP_W-1:0] cmp_cp;
    logic            cmp_ok;

    assign b       = i_in_item.data_byte;
    assign eos     = i_in_item.end_of_stream;
    assign is_cont = (b[7:6] == CONT_PFX);

    // continuations a fresh lead byte asks for
    always_comb begin
        if (b[7:5] == LEAD2_PFX) begin
            f_need = NEED_ONE;
        end else if (b[7:4] == LEAD3_PFX) begin
            f_need = NEED_TWO;
        end else if (b[7:3] == LEAD4_PFX) begin
            f_need = NEED_THREE;
        end else begin
            f_need = NEED_NONE;
        end
    end

    // this continuation closes the pending sequence
    assign seq_done = (({1'b0, r_have} + 3'd1) >= {1'b0, r_needed});

    // assemble the code point and check overlong, surrogate and range
    always_comb begin
        case (r_needed)
            NEED_ONE: begin
                cmp_cp = {10'd0, r_lead[4:0], b[5:0]};
                cmp_ok = (cmp_cp >= CP_MIN_2B);
            end
            NEED_TWO: begin
                cmp_cp = {5'd0, r_lead[3:0], r_held0[5:0], b[5:0]};
                cmp_ok = (cmp_cp >= CP_MIN_3B) &&
                         !((cmp_cp >= CP_SURR_LO) && (cmp_cp <= CP_SURR_HI));
            end
            NEED_THREE: begin
                cmp_cp = {r_lead[2:0], r_held0[5:0], r_held1[5:0], b[5:0]};
                cmp_ok = (cmp_cp >= CP_MIN_4B) && (cmp_cp <= CP_MAX);
            end
            default: begin
                cmp_cp = '0;
                cmp_ok = 1'b0;
            end
        endcase
    end

    // next decoder state and the job this byte produces
    logic do_fresh;

    always_comb begin
        n_lead      = r_lead;
        n_needed    = r_needed;
        n_have      = r_have;
        n_held0     = r_held0;
        n_held1     = r_held1;
        n_job_flush = 2'd0;
        n_job_final = 1'b0;
        n_job_cp    = '0;
        n_job_bad   = 1'b0;
        n_job_len   = LEN_ONE;
        do_fresh    = 1'b0;

        if (r_needed == NEED_NONE) begin
            do_fresh = 1'b1;
        end else if (is_cont) begin
            if (seq_done) begin
                n_job_final = 1'b1;
                n_job_cp    = cmp_cp;
                n_job_bad   = !cmp_ok;
                n_job_len   = {1'b0, r_needed} + 3'd1;
                n_needed    = NEED_NONE;
                n_have      = 2'd0;
            end else begin
                if (r_have[0]) begin
                    n_held1 = b;
                end else begin
                    n_held0 = b;
                end
                n_have = r_have + 2'd1;
                // early end: lead, held bytes and this one all go out invalid
                if (eos) begin
                    n_job_flush = r_have + 2'd2;
                    n_needed    = NEED_NONE;
                    n_have      = 2'd0;
                end
            end
        end else begin
            // mismatch: flush lead and held bytes, then decode this byte anew
            n_job_flush = r_have + 2'd1;
            n_needed    = NEED_NONE;
            n_have      = 2'd0;
            do_fresh    = 1'b1;
        end

        if (do_fresh) begin
            if (!b[7]) begin
                n_job_final = 1'b1;
                n_job_cp    = {13'd0, b};
            end else if ((f_need == NEED_NONE) || eos) begin
                n_job_final = 1'b1;
                n_job_bad   = 1'b1;
            end else begin
                n_lead   = b;
                n_needed = f_need;
                n_have   = 2'd0;
            end
        end
    end

    // ----------------------------------------------------------- emit stage
    logic             e_flush_now;
    logic             e_bad;
    logic [LEN_W-1:0] e_len;
    logic             e_last;

    assign e_flush_now = (r_job_flush != 2'd0);
    assign e_bad       = e_flush_now || r_job_bad;
    assign e_len       = e_flush_now ? LEN_ONE : r_job_len;
    assign e_last      = e_flush_now ? ((r_job_flush == 2'd1) && !r_job_final) : 1'b1;

    // saturating position updates
    logic [LINE_BITS:0] line_inc;
    logic [COL_BITS:0]  bcol_add;
    logic [COL_BITS:0]  ccol_inc;
    logic [COL_BITS:0]  ccol_tab;
    logic [COL_BITS-1:0] ccol_m1;

    assign line_inc = {1'b0, r_line} + {{LINE_BITS{1'b0}}, 1'b1};
    assign bcol_add = {1'b0, r_bcol} + (COL_BITS + 1)'(e_len);
    assign ccol_inc = {1'b0, r_ccol} + {{COL_BITS{1'b0}}, 1'b1};
    // next tab stop plus one: ((c - 1) | 7) + 2
    assign ccol_m1  = r_ccol - {{(COL_BITS-1){1'b0}}, 1'b1};
    assign ccol_tab = {1'b0, ccol_m1 | (COL_BITS)'(7)} + (COL_BITS + 1)'(2);

    always_comb begin
        n_line = r_line;
        n_bcol = r_bcol;
        n_ccol = r_ccol;
        if (pop) begin
            if (!e_bad && (r_job_cp == CP_LINE_FEED)) begin
                n_line = line_inc[LINE_BITS] ? r_line : line_inc[LINE_BITS-1:0];
                n_bcol = {{(COL_BITS-1){1'b0}}, 1'b1};
                n_ccol = {{(COL_BITS-1){1'b0}}, 1'b1};
            end else begin
                n_bcol = bcol_add[COL_BITS] ? {COL_BITS{1'b1}} : bcol_add[COL_BITS-1:0];
                if (!e_bad && (r_job_cp == CP_TAB)) begin
                    n_ccol = ccol_tab[COL_BITS] ? {COL_BITS{1'b1}}
                                                : ccol_tab[COL_BITS-1:0];
                end else begin
                    n_ccol = ccol_inc[COL_BITS] ? {COL_BITS{1'b1}}
                                                : ccol_inc[COL_BITS-1:0];
                end
            end
        end
    end

    // result register load
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (pop) begin
            n_out_valid             = 1'b1;
            n_out_item.code_point   = e_bad ? r_invalid_code : r_job_cp;
            n_out_item.invalid      = e_bad;
            n_out_item.seq_len      = e_len;
            n_out_item.line_number  = LINE_W'(32'(r_line));
            n_out_item.byte_column  = COL_W'(32'(r_bcol));
            n_out_item.char_column  = COL_W'(32'(r_ccol));
            n_out_item.last_of_run  = e_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // job register: load on accept, else drain one result per pop
    logic [1:0] j_flush;
    logic       j_final;

    always_comb begin
        j_flush = r_job_flush;
        j_final = r_job_final;
        if (accept) begin
            j_flush = n_job_flush;
            j_final = n_job_final;
        end else if (pop) begin
            if (e_flush_now) begin
                j_flush = r_job_flush - 2'd1;
            end else begin
                j_final = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needed    <= NEED_NONE;
            r_have      <= 2'd0;
            r_job_flush <= 2'd0;
            r_job_final <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            r_bcol      <= {{(COL_BITS-1){1'b0}}, 1'b1};
            r_ccol      <= {{(COL_BITS-1){1'b0}}, 1'b1};
        end else begin
            if (accept) begin
                r_needed <= n_needed;
                r_have   <= n_have;
            end
            r_job_flush <= j_flush;
            r_job_final <= j_final;
            r_out_valid <= n_out_valid;
            r_line      <= n_line;
            r_bcol      <= n_bcol;
            r_ccol      <= n_ccol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lead    <= n_lead;
            r_held0   <= n_held0;
            r_held1   <= n_held1;
            r_job_cp  <= n_job_cp;
            r_job_bad <= n_job_bad;
            r_job_len <= n_job_len;
        end
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> tb/tb_utf8_decoder_with_position_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_decoder_with_position_unit
// self-checking bench for the utf-8 decoder with line and column tracking
// ----------------------------------------------------------------------------
// a table of directed bytes comes first: ascii extremes, tab, line feed,
// stray bytes, good and bad multi-byte forms, a broken sequence and early
// stream ends. random byte streams follow, made mostly of whole code points
// with some broken sequences and noise. every accepted byte runs through a
// local decoder model and the predicted points are checked field by field,
// in order, against the output channel. the replacement code is changed
// between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_utf8_decoder_with_position_unit;
    import utf8d_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    // margin after the last due point before touching config
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_CAP      = 40;
    localparam int PHASE_ITEMS    = 28;
    localparam int DIR_ROWS       = 26;
    localparam int unsigned TAB_PITCH = 8;

    localparam longint unsigned LINE_TOP = (64'd1 << LINE_BITS_DEF) - 1;
    localparam longint unsigned COL_TOP  = (64'd1 << COL_BITS_DEF) - 1;

    // one directed byte; the typed fields apply to the first point it causes
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             end_of_stream;
        logic             typed;
        logic [CP_W-1:0]  code_point;
        logic             invalid;
        logic [LEN_W-1:0] seq_len;
    } t_dir_row;

    // dut inputs, all known from time zero
    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_cfg_we    = 1'b0;
    logic [CP_W-1:0] i_cfg_data  = '0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in_item   = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out_item;

    // decoder model state
    logic [CP_W-1:0] cur_code;
    logic [7:0]      seq_lead;
    logic [1:0]      seq_need;
    logic [1:0]      seq_have;
    logic [7:0]      seq_held [2];
    longint unsigned pos_line;
    longint unsigned pos_bcol;
    longint unsigned pos_ccol;

    // points caused by the last byte, and all points still due from the dut
    t_out_item byte_points [$];
    t_out_item points_due  [$];
    logic [7:0] stream_bytes [$];

    int unsigned err_cnt     = 0;
    int unsigned items_sent  = 0;
    int unsigned points_seen = 0;
    int unsigned cfg_writes  = 0;
    int unsigned quiet_cyc   = 0;
    int unsigned stall_left  = 0;
    bit          idling_on   = 1'b0;
    t_out_item   due_item;

    t_dir_row dir_table [DIR_ROWS] = '{
        // ascii extremes, tab and line feed
        '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0, 3'd1},
        '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0, 3'd1},
        '{8'h09, 1'b0, 1'b1, 21'h000009, 1'b0, 3'd1},
        '{8'h0A, 1'b0, 1'b1, 21'h00000A, 1'b0, 3'd1},
        // stray continuation and a byte that can never lead
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd1},
        '{8'hFF, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd1},
        // smallest two-byte point
        '{8'hC2, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b1, 21'h000080, 1'b0, 3'd2},
        // overlong two-byte form keeps its length
        '{8'hC0, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd2},
        // surrogate
        '{8'hED, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'hA0, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd3},
        // largest legal point
        '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h8F, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'hBF, 1'b0, 1'b1, 21'h10FFFF, 1'b0, 3'd4},
        // just above the legal range
        '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h90, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h80, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd4},
        // continuation mismatch: lead and held byte flushed, then 'A'
        '{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h9F, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h41, 1'b0, 1'b1, 21'h00FFFD, 1'b1, 3'd1},
        // stream ends inside a sequence, then on a bare lead
        '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0, 3'd0},
        '{8'h82, 1'b1, 1'b1, 21'h00FFFD, 1'b1, 3'd1}
    };

    utf8_decoder_with_position_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function automatic longint unsigned sat_add(longint unsigned v, longint unsigned add,
                                                longint unsigned top);
        return (v + add > top) ? top : v + add;
    endfunction

    // record one point at the current position, then move the position on
    function automatic void put_point(logic [CP_W-1:0] cp, logic bad, logic [LEN_W-1:0] len);
        t_out_item       pt;
        longint unsigned stop;
        pt.code_point  = bad ? cur_code : cp;
        pt.invalid     = bad;
        pt.seq_len     = len;
        pt.line_number = pos_line[LINE_W-1:0];
        pt.byte_column = pos_bcol[COL_W-1:0];
        pt.char_column = pos_ccol[COL_W-1:0];
        pt.last_of_run = 1'b0;
        byte_points.push_back(pt);
        // invalid points never count as line feed or tab, whatever the code
        if (!bad && cp == CP_LINE_FEED) begin
            pos_line = sat_add(pos_line, 1, LINE_TOP);
            pos_bcol = 1;
            pos_ccol = 1;
        end else if (!bad && cp == CP_TAB) begin
            stop     = ((pos_ccol - 1) / TAB_PITCH + 1) * TAB_PITCH;
            pos_bcol = sat_add(pos_bcol, 64'(len), COL_TOP);
            pos_ccol = sat_add(stop, 1, COL_TOP);
        end else begin
            pos_bcol = sat_add(pos_bcol, 64'(len), COL_TOP);
            pos_ccol = sat_add(pos_ccol, 1, COL_TOP);
        end
    endfunction

    // lead and every held byte each become an invalid single byte
    function automatic void flush_held();
        int i;
        put_point('0, 1'b1, LEN_ONE);
        for (i = 0; i < seq_have; i++)
            put_point('0, 1'b1, LEN_ONE);
        seq_need = NEED_NONE;
        seq_have = 2'd0;
    endfunction

    function automatic void begin_seq(logic [7:0] b, logic eos);
        logic [1:0] need;
        need = NEED_NONE;
        if (b[7] == 1'b0) begin
            put_point({13'd0, b}, 1'b0, LEN_ONE);
        end else begin
            if (b[7:5] == LEAD2_PFX)
                need = NEED_ONE;
            else if (b[7:4] == LEAD3_PFX)
                need = NEED_TWO;
            else if (b[7:3] == LEAD4_PFX)
                need = NEED_THREE;
            // a lead that is the last byte of the stream is flushed at once
            if (need == NEED_NONE || eos) begin
                put_point('0, 1'b1, LEN_ONE);
            end else begin
                seq_lead = b;
                seq_need = need;
                seq_have = 2'd0;
            end
        end
    endfunction

    function automatic void finish_seq(logic [7:0] b);
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             ok;
        int               i;
        len = {1'b0, seq_need} + 3'd1;
        case (seq_need)
            NEED_ONE: cp = {16'd0, seq_lead[4:0]};
            NEED_TWO: cp = {17'd0, seq_lead[3:0]};
            default:  cp = {18'd0, seq_lead[2:0]};
        endcase
        for (i = 0; i < seq_have; i++)
            cp = (cp << 6) | {15'd0, seq_held[i][5:0]};
        cp = (cp << 6) | {15'd0, b[5:0]};
        case (seq_need)
            NEED_ONE: ok = (cp >= CP_MIN_2B);
            NEED_TWO: ok = (cp >= CP_MIN_3B) && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
            default:  ok = (cp >= CP_MIN_4B) && (cp <= CP_MAX);
        endcase
        seq_need = NEED_NONE;
        seq_have = 2'd0;
        put_point(cp, !ok, len);
    endfunction

    // all points one accepted byte causes, appended to the due list
    function automatic void decode_byte(logic [7:0] b, logic eos);
        t_out_item pt;
        byte_points.delete();
        if (seq_need == NEED_NONE) begin
            begin_seq(b, eos);
        end else if (b[7:6] == CONT_PFX) begin
            if ({1'b0, seq_have} + 3'd1 >= {1'b0, seq_need}) begin
                finish_seq(b);
            end else begin
                seq_held[seq_have[0]] = b;
                seq_have = seq_have + 2'd1;
                if (eos)
                    flush_held();
            end
        end else begin
            flush_held();
            begin_seq(b, eos);
        end
        if (byte_points.size() != 0) begin
            pt = byte_points.pop_back();
            pt.last_of_run = 1'b1;
            byte_points.push_back(pt);
        end
        foreach (byte_points[i])
            points_due.push_back(byte_points[i]);
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic flag_field(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            if (err_cnt < PRINT_CAP)
                $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stall bursts, compare against the oldest due point
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            points_seen++;
            if (points_due.size() == 0) begin
                flag_field("unexpected point", {11'd0, o_out_item.code_point}, 32'hFFFFFFFF);
            end else begin
                due_item = points_due.pop_front();
                flag_field("code_point", 32'(o_out_item.code_point),
                           32'(due_item.code_point));
                flag_field("invalid", 32'(o_out_item.invalid), 32'(due_item.invalid));
                flag_field("seq_len", 32'(o_out_item.seq_len), 32'(due_item.seq_len));
                flag_field("line_number", 32'(o_out_item.line_number),
                           32'(due_item.line_number));
                flag_field("byte_column", 32'(o_out_item.byte_column),
                           32'(due_item.byte_column));
                flag_field("char_column", 32'(o_out_item.char_column),
                           32'(due_item.char_column));
                flag_field("last_of_run", 32'(o_out_item.last_of_run),
                           32'(due_item.last_of_run));
            end
        end
    end

    // watchdog on cycles where neither channel moves an item
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cyc = 0;
        else
            quiet_cyc = quiet_cyc + 1;
        if (quiet_cyc >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d points still due", points_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // offer one byte, wait for the handshake, then run the model on it
    task automatic feed_byte(input logic [7:0] b, input logic eos);
        t_in_item it;
        if (idling_on && $urandom_range(0, 11) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        it.data_byte     = b;
        it.end_of_stream = eos;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        decode_byte(b, eos);
        items_sent++;
    endtask

    // stop feeding and let every due point and the pipeline drain
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (points_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_invalid_code(input logic [CP_W-1:0] code);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= code;
        @(posedge i_clk);
        cur_code = code;
        cfg_writes++;
        i_cfg_we <= 1'b0;
    endtask

    // encode a value in a given number of bytes, whatever its size, and push the first keep of them
    task automatic push_encoded(input int unsigned len, input logic [CP_W-1:0] cp,
                                input int unsigned keep);
        logic [7:0] enc [4];
        int unsigned i;
        case (len)
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (i = 0; i < keep; i++)
            stream_bytes.push_back(enc[i]);
    endtask

    // one random character: mostly whole code points, some broken or noise
    task automatic gen_char();
        int unsigned kind;
        int unsigned len;
        logic [7:0]  b;
        logic [CP_W-1:0] cp;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            case ($urandom_range(0, 9))
                0: b = CP_LINE_FEED[7:0];
                1, 2: b = CP_TAB[7:0];
                default: b = 8'($urandom_range(0, 127));
            endcase
            stream_bytes.push_back(b);
        end else if (kind < 46) begin
            // a sixteenth of these are overlong
            cp = CP_W'($urandom_range(0, 'h7FF));
            push_encoded(2, cp, 2);
        end else if (kind < 62) begin
            if ($urandom_range(0, 5) == 0)
                cp = CP_W'($urandom_range('hD800, 'hDFFF));
            else
                cp = CP_W'($urandom_range(0, 'hFFFF));
            push_encoded(3, cp, 3);
        end else if (kind < 80) begin
            if ($urandom_range(0, 4) == 0)
                cp = CP_W'($urandom_range(0, 'h1FFFFF));
            else
                cp = CP_W'($urandom_range('h10000, 'h10FFFF));
            push_encoded(4, cp, 4);
        end else if (kind < 90) begin
            // truncated sequence: the next character breaks it
            len = $urandom_range(2, 4);
            cp  = CP_W'($urandom_range(0, 'h1FFFFF));
            push_encoded(len, cp, $urandom_range(1, len - 1));
        end else begin
            case ($urandom_range(0, 2))
                0: b = 8'($urandom_range('h80, 'hBF));
                1: b = 8'($urandom_range('hF8, 'hFF));
                default: b = 8'($urandom_range(0, 255));
            endcase
            stream_bytes.push_back(b);
        end
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        sent = 0;
        while (sent < n_items) begin
            gen_char();
            while (stream_bytes.size() != 0) begin
                // stream end now and then, often inside a sequence
                feed_byte(stream_bytes.pop_front(), ($urandom_range(0, 29) == 0));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_out_item head;
        int        r;

        // model starts from the reset state of the block
        cur_code = INVALID_CODE_RST;
        seq_lead = '0;
        seq_need = NEED_NONE;
        seq_have = 2'd0;
        seq_held[0] = '0;
        seq_held[1] = '0;
        pos_line = 1;
        pos_bcol = 1;
        pos_ccol = 1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table with the reset replacement code, no idling
        for (r = 0; r < DIR_ROWS; r++) begin
            feed_byte(dir_table[r].data_byte, dir_table[r].end_of_stream);
            if (dir_table[r].typed) begin
                if (byte_points.size() == 0) begin
                    flag_field("directed row without point", r, 32'hFFFFFFFF);
                end else begin
                    head = byte_points[0];
                    flag_field("directed code_point", 32'(head.code_point),
                               32'(dir_table[r].code_point));
                    flag_field("directed invalid", 32'(head.invalid),
                               32'(dir_table[r].invalid));
                    flag_field("directed seq_len", 32'(head.seq_len),
                               32'(dir_table[r].seq_len));
                end
            end
        end
        // bare lead as the last byte of the stream
        feed_byte(8'hDF, 1'b1);

        // random phases, each with its own replacement code
        idling_on = 1'b1;
        run_random(PHASE_ITEMS);
        write_invalid_code('0);
        run_random(PHASE_ITEMS);
        write_invalid_code({CP_W{1'b1}});
        run_random(PHASE_ITEMS);
        // invalid points carrying the line feed value must not act as one
        idling_on = 1'b0;
        write_invalid_code(CP_LINE_FEED);
        run_random(PHASE_ITEMS);
        idling_on = 1'b1;
        write_invalid_code(CP_TAB);
        run_random(PHASE_ITEMS);

        // random replacement code, no idling from here on
        idling_on = 1'b0;
        write_invalid_code(CP_W'($urandom_range(0, 'h1FFFFF)));
        run_random(PHASE_ITEMS);

        // closing phase, no idling on either side
        write_invalid_code(INVALID_CODE_RST);
        run_random(PHASE_ITEMS);

        drain_block();
        repeat (10) @(posedge i_clk);

        $display("fed %0d bytes, checked %0d code points, %0d replacement code writes",
                 items_sent, points_seen, cfg_writes);
        $display("covered directed forms, random streams, idling and replacement codes");
        if (err_cnt == 0 && points_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d points left over", err_cnt, points_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/utf8d_pkg.sv
design/utf8_decoder_with_position_unit.sv
tb/tb_utf8_decoder_with_position_unit.sv
